@@ hw/rtl/lsaf_pkg.sv @@
// Shared types, op3 codes and helper functions for the load/store align formatter.
package lsaf_pkg;

   localparam logic [5:0] OP_LD    = 6'd0;
   localparam logic [5:0] OP_LDUB  = 6'd1;
   localparam logic [5:0] OP_LDUH  = 6'd2;
   localparam logic [5:0] OP_LDD   = 6'd3;
   localparam logic [5:0] OP_ST    = 6'd4;
   localparam logic [5:0] OP_STB   = 6'd5;
   localparam logic [5:0] OP_STH   = 6'd6;
   localparam logic [5:0] OP_STD   = 6'd7;
   localparam logic [5:0] OP_LDSB  = 6'd9;
   localparam logic [5:0] OP_LDSH  = 6'd10;
   localparam logic [5:0] OP_LDF   = 6'd32;
   localparam logic [5:0] OP_LDFSR = 6'd33;
   localparam logic [5:0] OP_LDDF  = 6'd35;
   localparam logic [5:0] OP_STF   = 6'd36;
   localparam logic [5:0] OP_STFSR = 6'd37;
   localparam logic [5:0] OP_STDFQ = 6'd38;
   localparam logic [5:0] OP_STDF  = 6'd39;

   localparam logic [1:0] TRAP_NONE     = 2'd0;
   localparam logic [1:0] TRAP_MISALIGN = 2'd1;
   localparam logic [1:0] TRAP_FP       = 2'd2;
   localparam logic [1:0] TRAP_ILLEGAL  = 2'd3;

   localparam logic [1:0] KIND_NONE  = 2'd0;
   localparam logic [1:0] KIND_INT   = 2'd1;
   localparam logic [1:0] KIND_FLOAT = 2'd2;
   localparam logic [1:0] KIND_FSR   = 2'd3;

   localparam logic [2:0] FTT_NONE     = 3'd0;
   localparam logic [2:0] FTT_SEQUENCE = 3'd4;
   localparam logic [2:0] FTT_BAD_REG  = 3'd6;

   localparam logic [3:0] SIZE_NONE   = 4'd0;
   localparam logic [3:0] SIZE_BYTE   = 4'd1;
   localparam logic [3:0] SIZE_HALF   = 4'd2;
   localparam logic [3:0] SIZE_WORD   = 4'd4;
   localparam logic [3:0] SIZE_DOUBLE = 4'd8;

   localparam logic       CMD_ISSUE    = 1'b0;
   localparam logic       CMD_RESPONSE = 1'b1;

   typedef struct packed {
      logic        command;
      logic [5:0]  opcode3;
      logic [4:0]  dest_index;
      logic [31:0] address;
      logic [31:0] store_word;
      logic [31:0] store_word_next;
      logic [31:0] fsr_in;
      logic [63:0] load_bytes;
   } request_type;

   typedef struct packed {
      logic        mem_request;
      logic        mem_write;
      logic [3:0]  mem_size;
      logic [31:0] mem_address;
      logic [63:0] mem_wdata;
      logic [1:0]  trap_code;
      logic [1:0]  write_kind;
      logic [4:0]  write_index;
      logic [31:0] write_value;
      logic        pair_valid;
      logic [31:0] pair_value;
      logic [31:0] fsr_out;
   } result_type;

   function automatic logic [31:0] set_ftt(input logic [31:0] fsr, input logic [2:0] ftt);
      logic [31:0] r;
      r = fsr;
      r[16:14] = ftt;
      return r;
   endfunction

   function automatic result_type idle_result(input logic [31:0] fsr);
      result_type r;
      r = '0;
      r.fsr_out = fsr;
      return r;
   endfunction

   function automatic result_type fp_trap(input logic [31:0] fsr, input logic [2:0] ftt);
      result_type r;
      r = '0;
      r.trap_code   = TRAP_FP;
      r.write_kind  = KIND_FSR;
      r.write_value = set_ftt(fsr, ftt);
      r.fsr_out     = set_ftt(fsr, ftt);
      return r;
   endfunction

endpackage

@@ hw/rtl/sparc_load_store_align_format.sv @@
// Top level: input register, issue/response formatting, result register.
// A request passes through the input reg and then the result reg before result valid.
// Throughput: one request per cycle; both stages advance together unless rsp_stall
// holds a full result register.
// Reset: synchronous, active high; clears both stage valid flags only.
module sparc_load_store_align_format (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_command,
   input  logic [5:0]  req_opcode3,
   input  logic [4:0]  req_dest_index,
   input  logic [31:0] req_address,
   input  logic [31:0] req_store_word,
   input  logic [31:0] req_store_word_next,
   input  logic [31:0] req_fsr_in,
   input  logic [63:0] req_load_bytes,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_mem_request,
   output logic        rsp_mem_write,
   output logic [3:0]  rsp_mem_size,
   output logic [31:0] rsp_mem_address,
   output logic [63:0] rsp_mem_wdata,
   output logic [1:0]  rsp_trap_code,
   output logic [1:0]  rsp_write_kind,
   output logic [4:0]  rsp_write_index,
   output logic [31:0] rsp_write_value,
   output logic        rsp_pair_valid,
   output logic [31:0] rsp_pair_value,
   output logic [31:0] rsp_fsr_out
);

   lsaf_pkg::request_type req_in;
   lsaf_pkg::request_type req_ff;
   logic                  req_valid_ff;
   lsaf_pkg::result_type  issue_res;
   lsaf_pkg::result_type  resp_res;
   lsaf_pkg::result_type  res_in;
   lsaf_pkg::result_type  res_ff;
   logic                  res_valid_ff;
   logic                  res_load;
   logic                  req_load;

   assign res_load  = !res_valid_ff || !rsp_stall;
   assign req_load  = !req_valid_ff || res_load;
   assign req_stall = !req_load;

   assign req_in.command         = req_command;
   assign req_in.opcode3         = req_opcode3;
   assign req_in.dest_index      = req_dest_index;
   assign req_in.address         = req_address;
   assign req_in.store_word      = req_store_word;
   assign req_in.store_word_next = req_store_word_next;
   assign req_in.fsr_in          = req_fsr_in;
   assign req_in.load_bytes      = req_load_bytes;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_load) begin
         req_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_load && req_valid) begin
         req_ff <= req_in;
      end
   end

   lsaf_issue u_issue (
      .req (req_ff),
      .res (issue_res)
   );

   lsaf_response u_response (
      .req (req_ff),
      .res (resp_res)
   );

   assign res_in = (req_ff.command == lsaf_pkg::CMD_ISSUE) ? issue_res : resp_res;

   always_ff @(posedge clock) begin
      if (reset) begin
         res_valid_ff <= 1'b0;
      end else if (res_load) begin
         res_valid_ff <= req_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (res_load && req_valid_ff) begin
         res_ff <= res_in;
      end
   end

   assign rsp_valid       = res_valid_ff;
   assign rsp_mem_request = res_ff.mem_request;
   assign rsp_mem_write   = res_ff.mem_write;
   assign rsp_mem_size    = res_ff.mem_size;
   assign rsp_mem_address = res_ff.mem_address;
   assign rsp_mem_wdata   = res_ff.mem_wdata;
   assign rsp_trap_code   = res_ff.trap_code;
   assign rsp_write_kind  = res_ff.write_kind;
   assign rsp_write_index = res_ff.write_index;
   assign rsp_write_value = res_ff.write_value;
   assign rsp_pair_valid  = res_ff.pair_valid;
   assign rsp_pair_value  = res_ff.pair_value;
   assign rsp_fsr_out     = res_ff.fsr_out;

endmodule

@@ hw/rtl/lsaf_issue.sv @@
// Issue path: decode op3, check alignment and build the memory request.
module lsaf_issue (
   input  lsaf_pkg::request_type req,
   output lsaf_pkg::result_type  res
);

   logic [3:0]  size;
   logic        store;
   logic [2:0]  align_mask;
   logic [31:0] wword;

   always_comb begin
      case (req.opcode3)
         lsaf_pkg::OP_LDSB, lsaf_pkg::OP_LDUB, lsaf_pkg::OP_STB: size = lsaf_pkg::SIZE_BYTE;
         lsaf_pkg::OP_LDSH, lsaf_pkg::OP_LDUH, lsaf_pkg::OP_STH: size = lsaf_pkg::SIZE_HALF;
         lsaf_pkg::OP_LD, lsaf_pkg::OP_ST, lsaf_pkg::OP_LDF, lsaf_pkg::OP_LDFSR,
         lsaf_pkg::OP_STF, lsaf_pkg::OP_STFSR: size = lsaf_pkg::SIZE_WORD;
         lsaf_pkg::OP_LDD, lsaf_pkg::OP_STD, lsaf_pkg::OP_LDDF,
         lsaf_pkg::OP_STDF: size = lsaf_pkg::SIZE_DOUBLE;
         default: size = lsaf_pkg::SIZE_NONE;
      endcase
   end

   always_comb begin
      case (req.opcode3)
         lsaf_pkg::OP_ST, lsaf_pkg::OP_STB, lsaf_pkg::OP_STH, lsaf_pkg::OP_STD,
         lsaf_pkg::OP_STF, lsaf_pkg::OP_STFSR, lsaf_pkg::OP_STDF: store = 1'b1;
         default: store = 1'b0;
      endcase
   end

   // size 8 wraps to 0 in three bits, giving mask 7
   assign align_mask = size[2:0] - 3'd1;
   assign wword = (req.opcode3 == lsaf_pkg::OP_STFSR) ? req.fsr_in : req.store_word;

   always_comb begin
      res = lsaf_pkg::idle_result(req.fsr_in);
      if (req.opcode3 == lsaf_pkg::OP_STDFQ) begin
         res = lsaf_pkg::fp_trap(req.fsr_in, lsaf_pkg::FTT_SEQUENCE);
      end else if ((req.opcode3 == lsaf_pkg::OP_LDDF || req.opcode3 == lsaf_pkg::OP_STDF)
                   && req.dest_index[0]) begin
         res = lsaf_pkg::fp_trap(req.fsr_in, lsaf_pkg::FTT_BAD_REG);
      end else if (size == lsaf_pkg::SIZE_NONE) begin
         res.trap_code = lsaf_pkg::TRAP_ILLEGAL;
      end else if ((req.address[2:0] & align_mask) != 3'd0) begin
         res.trap_code = lsaf_pkg::TRAP_MISALIGN;
      end else begin
         res.mem_request = 1'b1;
         res.mem_size    = size;
         res.mem_address = req.address;
         if (store) begin
            res.mem_write = 1'b1;
            case (size)
               lsaf_pkg::SIZE_BYTE: res.mem_wdata = {wword[7:0], 56'd0};
               lsaf_pkg::SIZE_HALF: res.mem_wdata = {wword[15:0], 48'd0};
               lsaf_pkg::SIZE_WORD: res.mem_wdata = {wword, 32'd0};
               default:             res.mem_wdata = {wword, req.store_word_next};
            endcase
         end
      end
   end

endmodule

@@ hw/rtl/lsaf_response.sv @@
// Response path: extend and route returned bytes to the destination register.
module lsaf_response (
   input  lsaf_pkg::request_type req,
   output lsaf_pkg::result_type  res
);

   logic [31:0] hi;
   logic [31:0] lo;
   logic [7:0]  b;
   logic [15:0] h;

   assign hi = req.load_bytes[63:32];
   assign lo = req.load_bytes[31:0];
   assign b  = req.load_bytes[63:56];
   assign h  = req.load_bytes[63:48];

   always_comb begin
      res = lsaf_pkg::idle_result(req.fsr_in);
      case (req.opcode3)
         lsaf_pkg::OP_LD: begin
            res.write_kind  = lsaf_pkg::KIND_INT;
            res.write_index = req.dest_index;
            res.write_value = hi;
         end
         lsaf_pkg::OP_LDUB: begin
            res.write_kind  = lsaf_pkg::KIND_INT;
            res.write_index = req.dest_index;
            res.write_value = {24'd0, b};
         end
         lsaf_pkg::OP_LDUH: begin
            res.write_kind  = lsaf_pkg::KIND_INT;
            res.write_index = req.dest_index;
            res.write_value = {16'd0, h};
         end
         lsaf_pkg::OP_LDSB: begin
            res.write_kind  = lsaf_pkg::KIND_INT;
            res.write_index = req.dest_index;
            res.write_value = {{24{b[7]}}, b};
         end
         lsaf_pkg::OP_LDSH: begin
            res.write_kind  = lsaf_pkg::KIND_INT;
            res.write_index = req.dest_index;
            res.write_value = {{16{h[15]}}, h};
         end
         lsaf_pkg::OP_LDD: begin
            res.write_kind  = lsaf_pkg::KIND_INT;
            res.write_index = req.dest_index;
            res.write_value = hi;
            res.pair_valid  = 1'b1;
            res.pair_value  = lo;
         end
         lsaf_pkg::OP_LDF: begin
            res.write_kind  = lsaf_pkg::KIND_FLOAT;
            res.write_index = req.dest_index;
            res.write_value = hi;
         end
         lsaf_pkg::OP_LDFSR: begin
            res.write_kind  = lsaf_pkg::KIND_FSR;
            res.write_value = hi;
            res.fsr_out     = hi;
         end
         lsaf_pkg::OP_LDDF: begin
            if (req.dest_index[0]) begin
               res = lsaf_pkg::fp_trap(req.fsr_in, lsaf_pkg::FTT_BAD_REG);
            end else begin
               res.write_kind  = lsaf_pkg::KIND_FLOAT;
               res.write_index = req.dest_index;
               res.write_value = hi;
               res.pair_valid  = 1'b1;
               res.pair_value  = lo;
            end
         end
         lsaf_pkg::OP_STFSR: begin
            res.write_kind  = lsaf_pkg::KIND_FSR;
            res.write_value = lsaf_pkg::set_ftt(req.fsr_in, lsaf_pkg::FTT_NONE);
            res.fsr_out     = lsaf_pkg::set_ftt(req.fsr_in, lsaf_pkg::FTT_NONE);
         end
         lsaf_pkg::OP_STDFQ: res = lsaf_pkg::fp_trap(req.fsr_in, lsaf_pkg::FTT_SEQUENCE);
         lsaf_pkg::OP_ST, lsaf_pkg::OP_STB, lsaf_pkg::OP_STH, lsaf_pkg::OP_STD,
         lsaf_pkg::OP_STF, lsaf_pkg::OP_STDF: ;
         default: res.trap_code = lsaf_pkg::TRAP_ILLEGAL;
      endcase
   end

endmodule
